FILE: src/bir_pkg.sv
package bir_pkg;

    // Store geometry
    localparam int MAX_SOURCE_WIDTH  = 64;
    localparam int MAX_SOURCE_HEIGHT = 64;

    localparam int XW = (MAX_SOURCE_WIDTH > 1) ? $clog2(MAX_SOURCE_WIDTH) : 1;
    localparam int YW = (MAX_SOURCE_HEIGHT > 1) ? $clog2(MAX_SOURCE_HEIGHT) : 1;
    localparam int AW = (XW > YW) ? XW : YW;

    // Four banks split by row and column parity
    localparam int BXW        = (XW > 1) ? XW - 1 : 1;
    localparam int BYW        = (YW > 1) ? YW - 1 : 1;
    localparam int BANK_AW    = BXW + BYW;
    localparam int BANK_DEPTH = 2 ** BANK_AW;
    localparam int NUM_BANKS  = 4;

    // Field widths
    localparam int COORD_W = 10;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = CH_W * NUM_CH;
    localparam int SIZE_W  = 7;
    localparam int SCALE_W = 23;
    localparam int RES_W   = 18;

    // Fixed-point arithmetic
    localparam int FRAC_W  = 16;
    localparam int Q_ONE   = 65536;
    localparam int PROD_W  = COORD_W + 1 + SCALE_W;
    localparam int W1_W    = FRAC_W + 1;
    localparam int WW      = FRAC_W + 2;
    localparam int WT_W    = 2 * WW - FRAC_W;
    localparam int TERM_W  = CH_W + 1 + WT_W;
    localparam int ACC_W   = TERM_W + 2;
    localparam int SHR_W   = ACC_W - 8;
    localparam int RESULT_LOW  = -65536;
    localparam int RESULT_HIGH = 131071;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int APB_DW  = 32;

    localparam logic [SIZE_W-1:0]  SOURCE_WIDTH_RESET  = SIZE_W'(64);
    localparam logic [SIZE_W-1:0]  SOURCE_HEIGHT_RESET = SIZE_W'(64);
    localparam logic [SCALE_W-1:0] SCALE_RESET         = SCALE_W'(65536);

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_READ  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_SOURCE_WIDTH     = 2'd0,
        REG_SOURCE_HEIGHT    = 2'd1,
        REG_HORIZONTAL_SCALE = 2'd2,
        REG_VERTICAL_SCALE   = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [AW-1:0]          lo;
        logic [AW-1:0]          hi;
        logic signed [W1_W-1:0] w1;
    } axis_map_t;

endpackage

FILE: src/bir_in_if.sv
interface bir_in_if;
    import bir_pkg::*;

    logic               valid;
    logic               ready;
    opcode_t            opcode;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic [CH_W-1:0]    red_in;
    logic [CH_W-1:0]    green_in;
    logic [CH_W-1:0]    blue_in;

    modport source (
        output valid, opcode, column, row, red_in, green_in, blue_in,
        input  ready
    );

    modport sink (
        input  valid, opcode, column, row, red_in, green_in, blue_in,
        output ready
    );

endinterface

FILE: src/bir_out_if.sv
interface bir_out_if;
    import bir_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [COORD_W-1:0]      out_column;
    logic [COORD_W-1:0]      out_row;
    logic signed [RES_W-1:0] red_value;
    logic signed [RES_W-1:0] green_value;
    logic signed [RES_W-1:0] blue_value;

    modport source (
        output valid, out_column, out_row, red_value, green_value, blue_value,
        input  ready
    );

    modport sink (
        input  valid, out_column, out_row, red_value, green_value, blue_value,
        output ready
    );

endinterface

FILE: src/bir_ram.sv
module bir_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: src/bir_axis_map.sv
module bir_axis_map (
    input  logic [bir_pkg::PROD_W-1:0] product,
    input  logic [bir_pkg::AW-1:0]     last,
    output bir_pkg::axis_map_t         axis
);
    import bir_pkg::*;

    localparam logic signed [PROD_W-1:0] HALF = PROD_W'(Q_ONE / 2);

    logic signed [PROD_W-1:0] f;
    logic signed [PROD_W-1:0] top;
    logic signed [PROD_W-1:0] fc;
    logic [AW-1:0]            base;

    always_comb
    begin
        // (2d+1)*scale/2 - 0.5, then saturate past the last sample
        f    = $signed({1'b0, product[PROD_W-1:1]}) - HALF;
        top  = $signed(PROD_W'({last, {FRAC_W{1'b1}}}));
        fc   = (f > top) ? top : f;
        base = fc[PROD_W-1] ? '0 : fc[FRAC_W +: AW];

        axis.lo = base;
        axis.hi = (base == last) ? last : base + AW'(1);
        // negative coordinate keeps its sign as an extrapolating weight
        axis.w1 = fc[PROD_W-1] ? fc[W1_W-1:0] : {1'b0, fc[FRAC_W-1:0]};
    end

endmodule

FILE: src/bilinear_image_resize.sv
// A read passes the stage 2 to 5 and output registers, moving only while no result is held;
// a write gives no result and updates the store from stage 2 when the pipeline advances.
// Throughput: one transaction per cycle, reads and writes freely mixed; four row/column-parity
// banks give all four neighbours in one read. A held result stalls the pipeline and input.
// Reset (rst_n, async low) restores the size and scale registers and empties the pipeline;
// the frame store is not cleared and holds nothing useful until written.
module bilinear_image_resize (
    input  logic                         clk,
    input  logic                         rst_n,
    bir_in_if.sink                       pixel_in,
    bir_out_if.source                    pixel_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bir_pkg::PADDR_W-1:0]  paddr,
    input  logic [bir_pkg::APB_DW-1:0]   pwdata,
    output logic [bir_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import bir_pkg::*;

    function automatic logic [BANK_AW-1:0] bank_addr(input logic [AW-1:0] y,
                                                     input logic [AW-1:0] x);
        return {BYW'(y[YW-1:0] >> 1), BXW'(x[XW-1:0] >> 1)};
    endfunction

    // Configuration registers
    logic [SIZE_W-1:0]  src_width_reg;
    logic [SIZE_W-1:0]  src_height_reg;
    logic [SCALE_W-1:0] hscale_reg;
    logic [SCALE_W-1:0] vscale_reg;
    logic               apb_write;
    reg_index_t         reg_sel;

    // Pipeline
    logic                    adv;
    logic                    s2_valid_reg;
    logic                    s3_valid_reg;
    logic                    s4_valid_reg;
    logic                    s5_valid_reg;
    logic                    out_valid_reg;
    opcode_t                 s2_op_reg;
    logic [COORD_W-1:0]      s2_col_reg;
    logic [COORD_W-1:0]      s2_row_reg;
    logic [PIX_W-1:0]        s2_pix_reg;
    logic [PROD_W-1:0]       s2_px_prod_reg;
    logic [PROD_W-1:0]       s2_py_prod_reg;
    logic [PROD_W-1:0]       s2_px_prod_next;
    logic [PROD_W-1:0]       s2_py_prod_next;

    logic [COORD_W-1:0]      s3_col_reg;
    logic [COORD_W-1:0]      s3_row_reg;
    logic signed [W1_W-1:0]  s3_wx1_reg;
    logic signed [W1_W-1:0]  s3_wy1_reg;
    logic                    s3_x0p_reg;
    logic                    s3_x1p_reg;
    logic                    s3_y0p_reg;
    logic                    s3_y1p_reg;

    logic [COORD_W-1:0]      s4_col_reg;
    logic [COORD_W-1:0]      s4_row_reg;
    logic signed [WT_W-1:0]  s4_wgt_reg [NUM_BANKS];
    logic [PIX_W-1:0]        s4_pix_reg [NUM_BANKS];

    logic [COORD_W-1:0]      s5_col_reg;
    logic [COORD_W-1:0]      s5_row_reg;
    logic signed [TERM_W-1:0] s5_term_reg [NUM_CH][NUM_BANKS];

    logic [COORD_W-1:0]      out_col_reg;
    logic [COORD_W-1:0]      out_row_reg;
    logic signed [RES_W-1:0] out_val_reg [NUM_CH];

    // Mapping and store access
    logic [AW-1:0]           last_x;
    logic [AW-1:0]           last_y;
    axis_map_t               ax;
    axis_map_t               ay;
    logic                    wr_in_range;
    logic [1:0]              wr_bank;
    logic [BANK_AW-1:0]      wr_addr;
    logic                    bank_we   [NUM_BANKS];
    logic [BANK_AW-1:0]      bank_raddr [NUM_BANKS];
    logic [PIX_W-1:0]        bank_rdata [NUM_BANKS];

    // Stage 3 and later combinational
    logic [PIX_W-1:0]        nbr        [NUM_BANKS];
    logic signed [WW-1:0]    wx0;
    logic signed [WW-1:0]    wx1;
    logic signed [WW-1:0]    wy0;
    logic signed [WW-1:0]    wy1;
    logic signed [2*WW-1:0]  pair_wgt   [NUM_BANKS];
    logic signed [TERM_W-1:0] term_next [NUM_CH][NUM_BANKS];
    logic signed [ACC_W-1:0] acc        [NUM_CH];
    logic signed [SHR_W-1:0] shr        [NUM_CH];
    logic signed [RES_W-1:0] sat_next   [NUM_CH];

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign apb_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[PADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SOURCE_WIDTH_RESET;
            src_height_reg <= SOURCE_HEIGHT_RESET;
            hscale_reg     <= SCALE_RESET;
            vscale_reg     <= SCALE_RESET;
        end
        else if (apb_write)
        begin
            case (reg_sel)
                REG_SOURCE_WIDTH:     src_width_reg  <= pwdata[SIZE_W-1:0];
                REG_SOURCE_HEIGHT:    src_height_reg <= pwdata[SIZE_W-1:0];
                REG_HORIZONTAL_SCALE: hscale_reg     <= pwdata[SCALE_W-1:0];
                REG_VERTICAL_SCALE:   vscale_reg     <= pwdata[SCALE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_SOURCE_WIDTH:     prdata = APB_DW'(src_width_reg);
            REG_SOURCE_HEIGHT:    prdata = APB_DW'(src_height_reg);
            REG_HORIZONTAL_SCALE: prdata = APB_DW'(hscale_reg);
            REG_VERTICAL_SCALE:   prdata = APB_DW'(vscale_reg);
            default:              prdata = '0;
        endcase
    end

    // Effective last column and row: a size of zero acts as one, larger ones saturate
    always_comb
    begin
        if (src_width_reg == '0)
            last_x = '0;
        else if (int'(src_width_reg) > MAX_SOURCE_WIDTH)
            last_x = AW'(MAX_SOURCE_WIDTH - 1);
        else
            last_x = AW'(src_width_reg - SIZE_W'(1));

        if (src_height_reg == '0)
            last_y = '0;
        else if (int'(src_height_reg) > MAX_SOURCE_HEIGHT)
            last_y = AW'(MAX_SOURCE_HEIGHT - 1);
        else
            last_y = AW'(src_height_reg - SIZE_W'(1));
    end

    // ---------------- handshake ----------------
    // advance everything unless a result sits unread at the output
    assign adv            = !out_valid_reg || pixel_out.ready;
    assign pixel_in.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg  <= pixel_in.valid;
            s3_valid_reg  <= s2_valid_reg && (s2_op_reg == OP_READ);
            s4_valid_reg  <= s3_valid_reg;
            s5_valid_reg  <= s4_valid_reg;
            out_valid_reg <= s5_valid_reg;
        end
    end

    // ---------------- stage 1: coordinate products ----------------
    assign s2_px_prod_next = PROD_W'({pixel_in.column, 1'b1}) * PROD_W'(hscale_reg);
    assign s2_py_prod_next = PROD_W'({pixel_in.row, 1'b1}) * PROD_W'(vscale_reg);

    // ---------------- stage 2: map axes, access banks ----------------
    bir_axis_map u_map_x (
        .product (s2_px_prod_reg),
        .last    (last_x),
        .axis    (ax)
    );

    bir_axis_map u_map_y (
        .product (s2_py_prod_reg),
        .last    (last_y),
        .axis    (ay)
    );

    assign wr_in_range = (int'(s2_col_reg) < MAX_SOURCE_WIDTH) &&
                         (int'(s2_row_reg) < MAX_SOURCE_HEIGHT);
    assign wr_bank     = {s2_row_reg[0], s2_col_reg[0]};
    assign wr_addr     = bank_addr(AW'(s2_row_reg), AW'(s2_col_reg));

    always_comb
    begin
        for (int b = 0; b < NUM_BANKS; b++)
        begin
            bank_we[b] = adv && s2_valid_reg && (s2_op_reg == OP_WRITE) && wr_in_range &&
                         (wr_bank == 2'(b));
            // each bank serves whichever neighbour has its parity
            bank_raddr[b] = bank_addr((ay.lo[0] == b[1]) ? ay.lo : ay.hi,
                                      (ax.lo[0] == b[0]) ? ax.lo : ax.hi);
        end
    end

    for (genvar g = 0; g < NUM_BANKS; g++)
    begin : g_bank
        bir_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (bank_we[g]),
            .waddr (wr_addr),
            .wdata (s2_pix_reg),
            .re    (adv),
            .raddr (bank_raddr[g]),
            .rdata (bank_rdata[g])
        );
    end

    // ---------------- stage 3: pair weights ----------------
    always_comb
    begin
        nbr[0] = bank_rdata[{s3_y0p_reg, s3_x0p_reg}];
        nbr[1] = bank_rdata[{s3_y0p_reg, s3_x1p_reg}];
        nbr[2] = bank_rdata[{s3_y1p_reg, s3_x0p_reg}];
        nbr[3] = bank_rdata[{s3_y1p_reg, s3_x1p_reg}];

        wx1 = WW'(s3_wx1_reg);
        wy1 = WW'(s3_wy1_reg);
        wx0 = WW'(Q_ONE) - wx1;
        wy0 = WW'(Q_ONE) - wy1;

        pair_wgt[0] = wy0 * wx0;
        pair_wgt[1] = wy0 * wx1;
        pair_wgt[2] = wy1 * wx0;
        pair_wgt[3] = wy1 * wx1;
    end

    // ---------------- stage 4: per-channel terms ----------------
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int k = 0; k < NUM_BANKS; k++)
            begin
                term_next[c][k] = $signed({1'b0, s4_pix_reg[k][CH_W*c +: CH_W]}) *
                                  s4_wgt_reg[k];
            end
        end
    end

    // ---------------- stage 5: sum, floor to Q8, saturate ----------------
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc[c] = ACC_W'(s5_term_reg[c][0]) + ACC_W'(s5_term_reg[c][1]) +
                     ACC_W'(s5_term_reg[c][2]) + ACC_W'(s5_term_reg[c][3]);
            shr[c] = $signed(acc[c][ACC_W-1:8]);
            if (shr[c] < $signed(SHR_W'(RESULT_LOW)))
                sat_next[c] = RES_W'(RESULT_LOW);
            else if (shr[c] > $signed(SHR_W'(RESULT_HIGH)))
                sat_next[c] = RES_W'(RESULT_HIGH);
            else
                sat_next[c] = shr[c][RES_W-1:0];
        end
    end

    // ---------------- payload registers ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg      <= pixel_in.opcode;
            s2_col_reg     <= pixel_in.column;
            s2_row_reg     <= pixel_in.row;
            s2_pix_reg     <= {pixel_in.blue_in, pixel_in.green_in, pixel_in.red_in};
            s2_px_prod_reg <= s2_px_prod_next;
            s2_py_prod_reg <= s2_py_prod_next;

            s3_col_reg <= s2_col_reg;
            s3_row_reg <= s2_row_reg;
            s3_wx1_reg <= ax.w1;
            s3_wy1_reg <= ay.w1;
            s3_x0p_reg <= ax.lo[0];
            s3_x1p_reg <= ax.hi[0];
            s3_y0p_reg <= ay.lo[0];
            s3_y1p_reg <= ay.hi[0];

            s4_col_reg <= s3_col_reg;
            s4_row_reg <= s3_row_reg;
            for (int k = 0; k < NUM_BANKS; k++)
            begin
                // floor of the Q32 pair product back to Q16
                s4_wgt_reg[k] <= $signed(pair_wgt[k][2*WW-1:FRAC_W]);
                s4_pix_reg[k] <= nbr[k];
            end

            s5_col_reg  <= s4_col_reg;
            s5_row_reg  <= s4_row_reg;
            s5_term_reg <= term_next;

            out_col_reg <= s5_col_reg;
            out_row_reg <= s5_row_reg;
            out_val_reg <= sat_next;
        end
    end

    assign pixel_out.valid       = out_valid_reg;
    assign pixel_out.out_column  = out_col_reg;
    assign pixel_out.out_row     = out_row_reg;
    assign pixel_out.red_value   = out_val_reg[0];
    assign pixel_out.green_value = out_val_reg[1];
    assign pixel_out.blue_value  = out_val_reg[2];

endmodule

FILE: src/bir_checker.sv
module bir_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [bir_pkg::COORD_W-1:0]  out_column,
    input logic [bir_pkg::COORD_W-1:0]  out_row,
    input logic [bir_pkg::RES_W-1:0]    red_value,
    input logic [bir_pkg::RES_W-1:0]    green_value,
    input logic [bir_pkg::RES_W-1:0]    blue_value,
    input logic                         psel,
    input logic                         penable,
    input logic                         pwrite,
    input logic [bir_pkg::PADDR_W-1:0]  paddr,
    input logic [bir_pkg::APB_DW-1:0]   pwdata,
    input logic [bir_pkg::APB_DW-1:0]   prdata,
    input logic                         pready
);
    import bir_pkg::*;

    // held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_column) && $stable(out_row) &&
        $stable(red_value) && $stable(green_value) && $stable(blue_value))
        else $error("result changed while held");

    // input back-pressure comes only from a held result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a held result");

    // no result straight after a reset cycle
    a_reset_empty: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result shown during reset");

    // width register reads back what was last written
    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[PADDR_W-1:2] == REG_SOURCE_WIDTH))
        ##1 (paddr[PADDR_W-1:2] == REG_SOURCE_WIDTH)
        |-> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
        else $error("width register readback mismatch");

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (pixel_in.ready),
    .out_valid   (pixel_out.valid),
    .out_ready   (pixel_out.ready),
    .out_column  (pixel_out.out_column),
    .out_row     (pixel_out.out_row),
    .red_value   (pixel_out.red_value),
    .green_value (pixel_out.green_value),
    .blue_value  (pixel_out.blue_value),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
);
